// ===== hw/rtl/ruci_pkg.sv =====
package ruci_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int COORD_WIDTH = 32;
    localparam int DIST_WIDTH  = COORD_WIDTH - 1;
    localparam int EPS_WIDTH   = 16;
    localparam int IW          = 64;
    localparam int HW          = IW / 2;
    localparam int DIV_STAGES  = IW + FRAC_BITS;
    localparam int SQRT_STAGES = (IW + 2 * FRAC_BITS) / 2;
    localparam int IN_W        = ((6 * COORD_WIDTH + DIST_WIDTH + 7) / 8) * 8;
    localparam int OUT_W       = ((3 * COORD_WIDTH + DIST_WIDTH + 7) / 8) * 8;

    typedef logic signed [IW-1:0] fx_t;

    typedef struct packed {
        logic          neg;
        logic [IW-1:0] p_hh, p_hl, p_lh, p_ll;
    } mpp_t;

    localparam logic [IW-1:0] LIMU = {2'b00, {(IW-2){1'b1}}};
    localparam fx_t LIMV = fx_t'(LIMU);
    localparam fx_t ONEV = fx_t'(1) <<< FRAC_BITS;
    localparam fx_t CMAX = fx_t'({1'b0, {(COORD_WIDTH-1){1'b1}}});
    localparam fx_t CMIN = -CMAX - fx_t'(1);

    typedef struct packed {
        fx_t  ox, oy, oz, dx, dy, dz, best;
        fx_t  p_dxdx, p_dzdz, p_oxdx, p_ozdz, p_oxox, p_ozoz;
        fx_t  cn0, cn1, a, b, c, bb, ac, disc, s, q;
        fx_t  tt, t0, t1;
        fx_t  m_ty, m_tx, m_tz, m_0x, m_0z, m_1x, m_1z;
        fx_t  y, nx, nz, x0, z0, x1, z1;
        fx_t  sx0, sz0, sx1, sz1;
        logic side_ok;
    } pipe_t;

    function automatic fx_t sext_coord(logic [COORD_WIDTH-1:0] v);
        return fx_t'(signed'(v));
    endfunction

    function automatic fx_t sat_add(fx_t x, fx_t y);
        logic signed [IW:0] s;
        s = (IW+1)'(x) + (IW+1)'(y);
        if (s > (IW+1)'(LIMV)) return LIMV;
        if (s < -((IW+1)'(LIMV))) return -LIMV;
        return s[IW-1:0];
    endfunction

    // coordinate by coordinate: magnitudes fit one 32x32 product
    function automatic fx_t fmul_c(logic [COORD_WIDTH-1:0] x, logic [COORD_WIDTH-1:0] y);
        logic [COORD_WIDTH-1:0]   ma, mb;
        logic [2*COORD_WIDTH-1:0] p;
        fx_t                      m;
        ma = x[COORD_WIDTH-1] ? -x : x;
        mb = y[COORD_WIDTH-1] ? -y : y;
        p  = (2*COORD_WIDTH)'(ma) * (2*COORD_WIDTH)'(mb);
        m  = fx_t'(p >> FRAC_BITS);
        return (x[COORD_WIDTH-1] ^ y[COORD_WIDTH-1]) ? -m : m;
    endfunction

    // first half of a wide multiply: four 32x32 partial products
    function automatic mpp_t mul_pp(fx_t x, fx_t y);
        logic [IW-1:0] ma, mb;
        mpp_t          r;
        ma     = x[IW-1] ? IW'(-x) : IW'(x);
        mb     = y[IW-1] ? IW'(-y) : IW'(y);
        r.neg  = x[IW-1] ^ y[IW-1];
        r.p_hh = IW'(ma[IW-1:HW]) * IW'(mb[IW-1:HW]);
        r.p_hl = IW'(ma[IW-1:HW]) * IW'(mb[HW-1:0]);
        r.p_lh = IW'(ma[HW-1:0]) * IW'(mb[IW-1:HW]);
        r.p_ll = IW'(ma[HW-1:0]) * IW'(mb[HW-1:0]);
        return r;
    endfunction

    // second half: sum, scale, saturate, sign
    function automatic fx_t mul_fin(mpp_t pp);
        logic [2*IW-1:0] p, sh;
        fx_t             m;
        p  = {pp.p_hh, {IW{1'b0}}} + ((2*IW)'(pp.p_hl) << HW) +
             ((2*IW)'(pp.p_lh) << HW) + (2*IW)'(pp.p_ll);
        sh = p >> FRAC_BITS;
        m  = (sh > (2*IW)'(LIMU)) ? LIMV : fx_t'(sh[IW-1:0]);
        return pp.neg ? -m : m;
    endfunction

    function automatic logic [COORD_WIDTH-1:0] clamp_coord(fx_t v);
        fx_t r;
        r = v;
        if (v > CMAX) r = CMAX;
        if (v < CMIN) r = CMIN;
        return r[COORD_WIDTH-1:0];
    endfunction

endpackage

// ===== hw/rtl/ruci_sqrt.sv =====
module ruci_sqrt
    import ruci_pkg::*;
(
    input  logic aclk,
    input  logic en,
    input  fx_t  radicand,
    output fx_t  root
);
    localparam int N     = SQRT_STAGES;
    localparam int RAD_W = 2 * N;
    localparam int REM_W = N + 4;

    logic [RAD_W-1:0] rad_reg  [1:N];
    logic [REM_W-1:0] rem_reg  [1:N];
    logic [N-1:0]     root_reg [1:N];

    logic [RAD_W-1:0] rad_cur  [0:N-1];
    logic [REM_W-1:0] rem_cur  [0:N-1];
    logic [N-1:0]     root_cur [0:N-1];
    logic [RAD_W-1:0] rad_next [0:N-1];
    logic [REM_W-1:0] rem_next [0:N-1];
    logic [N-1:0]     root_next[0:N-1];

    always_comb begin
        logic [REM_W-1:0] r2, trial;
        for (int k = 0; k < N; k++) begin
            if (k == 0) begin
                rad_cur[k]  = RAD_W'({radicand, {FRAC_BITS{1'b0}}});
                rem_cur[k]  = '0;
                root_cur[k] = '0;
            end else begin
                rad_cur[k]  = rad_reg[k];
                rem_cur[k]  = rem_reg[k];
                root_cur[k] = root_reg[k];
            end
            r2    = {rem_cur[k][REM_W-3:0], rad_cur[k][RAD_W-1 -: 2]};
            trial = REM_W'({root_cur[k], 2'b01});
            rad_next[k] = rad_cur[k] << 2;
            if (r2 >= trial) begin
                rem_next[k]  = r2 - trial;
                root_next[k] = {root_cur[k][N-2:0], 1'b1};
            end else begin
                rem_next[k]  = r2;
                root_next[k] = {root_cur[k][N-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < N; k++) begin
                rad_reg[k+1]  <= rad_next[k];
                rem_reg[k+1]  <= rem_next[k];
                root_reg[k+1] <= root_next[k];
            end
        end
    end

    assign root = fx_t'(root_reg[N]);

endmodule

// ===== hw/rtl/ruci_div.sv =====
module ruci_div
    import ruci_pkg::*;
(
    input  logic aclk,
    input  logic en,
    input  fx_t  num,
    input  fx_t  den,
    output fx_t  quo
);
    localparam int N     = DIV_STAGES;
    localparam int DVD_W = IW + FRAC_BITS;

    logic [DVD_W-1:0] dvd_reg [1:N];
    logic [IW-1:0]    rem_reg [1:N];
    logic [DVD_W-1:0] quo_reg [1:N];
    logic [IW-1:0]    den_reg [1:N];
    logic             neg_reg [1:N];

    logic [DVD_W-1:0] dvd_cur [0:N-1];
    logic [IW-1:0]    rem_cur [0:N-1];
    logic [DVD_W-1:0] quo_cur [0:N-1];
    logic [IW-1:0]    den_cur [0:N-1];
    logic             neg_cur [0:N-1];
    logic [IW-1:0]    rem_next[0:N-1];
    logic [DVD_W-1:0] quo_next[0:N-1];

    logic [IW-1:0] un, ud;
    fx_t           mq;

    assign un = num[IW-1] ? IW'(-num) : IW'(num);
    assign ud = den[IW-1] ? IW'(-den) : IW'(den);

    always_comb begin
        logic [IW:0] r2;
        for (int k = 0; k < N; k++) begin
            if (k == 0) begin
                dvd_cur[k] = {un, {FRAC_BITS{1'b0}}};
                rem_cur[k] = '0;
                quo_cur[k] = '0;
                den_cur[k] = ud;
                neg_cur[k] = num[IW-1] ^ den[IW-1];
            end else begin
                dvd_cur[k] = dvd_reg[k];
                rem_cur[k] = rem_reg[k];
                quo_cur[k] = quo_reg[k];
                den_cur[k] = den_reg[k];
                neg_cur[k] = neg_reg[k];
            end
            r2 = {rem_cur[k], dvd_cur[k][DVD_W-1]};
            if (r2 >= {1'b0, den_cur[k]}) begin
                rem_next[k] = IW'(r2 - {1'b0, den_cur[k]});
                quo_next[k] = {quo_cur[k][DVD_W-2:0], 1'b1};
            end else begin
                rem_next[k] = r2[IW-1:0];
                quo_next[k] = {quo_cur[k][DVD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < N; k++) begin
                dvd_reg[k+1] <= dvd_cur[k] << 1;
                rem_reg[k+1] <= rem_next[k];
                quo_reg[k+1] <= quo_next[k];
                den_reg[k+1] <= den_cur[k];
                neg_reg[k+1] <= neg_cur[k];
            end
        end
    end

    assign mq  = (quo_reg[N] > DVD_W'(LIMU)) ? LIMV : fx_t'(quo_reg[N][IW-1:0]);
    assign quo = neg_reg[N] ? -mq : mq;

endmodule

// ===== hw/rtl/ray_unit_cylinder_intersect_core.sv =====
// Channel  Dir  Beat contents
// s_       in   tdata: origin x/y/z, dir x/y/z, best distance
// m_       out  tdata: new distance, normal x/y/z; tuser: hit
// cfg_     in   data: epsilon (Q0.16, unsigned)
//
// One ray per cycle while m_ is not stalled. Depth is set by the 48-step square
// root pipeline and the 80-step restoring dividers.
// aresetn (sync, low) clears all valid bits and sets epsilon to 1 LSB (2^-16).
// A stall on m_ freezes the whole pipeline; s_tready follows the output slot.
module ray_unit_cylinder_intersect_core
    import ruci_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, best_distance, pad
    input  logic [IN_W-1:0]       s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // new_distance, normal_x, normal_y, normal_z, pad
    output logic [OUT_W-1:0]      m_tdata,
    // hit
    output logic [0:0]            m_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [EPS_WIDTH-1:0]  cfg_data
);
    localparam int CW = COORD_WIDTH;

    logic [EPS_WIDTH-1:0] epsilon_reg;
    logic                 en;
    fx_t                  eps;

    pipe_t st1_reg, st2_reg, st3_reg, st4_reg, st5_reg, st6_reg, st7_reg, st8_reg, st9_reg;
    pipe_t st1_next, st2_next, st3_next, st4_next, st5_next, st6_next, st7_next;
    pipe_t st8_next, st9_next;
    pipe_t st2m_reg, st6m_reg, st8m_reg;
    logic  v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg, v9_reg;
    logic  v2m_reg, v6m_reg, v8m_reg;

    mpp_t  mp2_reg [2];
    mpp_t  mp2_next[2];
    mpp_t  mp6_reg [7];
    mpp_t  mp6_next[7];
    mpp_t  mp8_reg [4];
    mpp_t  mp8_next[4];

    pipe_t sq_ctx_reg [1:SQRT_STAGES];
    logic  sq_v_reg   [1:SQRT_STAGES];
    pipe_t dv_ctx_reg [1:DIV_STAGES];
    logic  dv_v_reg   [1:DIV_STAGES];

    fx_t sq_root, d_qa, d_cq, d_t0, d_t1;

    logic                 m_tvalid_reg;
    logic [OUT_W-1:0]     m_tdata_reg, m_tdata_next;
    logic                 hit_reg, hit_next;

    assign en        = !m_tvalid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;
    assign eps       = fx_t'(epsilon_reg);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = hit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            epsilon_reg <= EPS_WIDTH'(1);
        end else if (cfg_valid) begin
            epsilon_reg <= cfg_data;
        end
    end

    always_comb begin
        st1_next     = '0;
        st1_next.ox  = sext_coord(s_tdata[0*CW +: CW]);
        st1_next.oy  = sext_coord(s_tdata[1*CW +: CW]);
        st1_next.oz  = sext_coord(s_tdata[2*CW +: CW]);
        st1_next.dx  = sext_coord(s_tdata[3*CW +: CW]);
        st1_next.dy  = sext_coord(s_tdata[4*CW +: CW]);
        st1_next.dz  = sext_coord(s_tdata[5*CW +: CW]);
        st1_next.best = fx_t'(s_tdata[6*CW +: DIST_WIDTH]);
        st1_next.p_dxdx = fmul_c(s_tdata[3*CW +: CW], s_tdata[3*CW +: CW]);
        st1_next.p_dzdz = fmul_c(s_tdata[5*CW +: CW], s_tdata[5*CW +: CW]);
        st1_next.p_oxdx = fmul_c(s_tdata[0*CW +: CW], s_tdata[3*CW +: CW]);
        st1_next.p_ozdz = fmul_c(s_tdata[2*CW +: CW], s_tdata[5*CW +: CW]);
        st1_next.p_oxox = fmul_c(s_tdata[0*CW +: CW], s_tdata[0*CW +: CW]);
        st1_next.p_ozoz = fmul_c(s_tdata[2*CW +: CW], s_tdata[2*CW +: CW]);
        st1_next.cn0 = sat_add(ONEV, -st1_next.oy);
        st1_next.cn1 = sat_add(-ONEV, -st1_next.oy);
    end

    always_comb begin
        fx_t t;
        st2_next   = st1_reg;
        st2_next.a = sat_add(st1_reg.p_dxdx, st1_reg.p_dzdz);
        t          = sat_add(st1_reg.p_oxdx, st1_reg.p_ozdz);
        st2_next.b = sat_add(t, t);
        st2_next.c = sat_add(sat_add(st1_reg.p_oxox, st1_reg.p_ozoz), -ONEV);
    end

    always_comb begin
        mp2_next[0] = mul_pp(st2_reg.b, st2_reg.b);
        mp2_next[1] = mul_pp(st2_reg.a, st2_reg.c);
    end

    always_comb begin
        st3_next    = st2m_reg;
        st3_next.bb = mul_fin(mp2_reg[0]);
        st3_next.ac = mul_fin(mp2_reg[1]);
    end

    always_comb begin
        fx_t t;
        st4_next      = st3_reg;
        t             = sat_add(st3_reg.ac, st3_reg.ac);
        t             = sat_add(t, t);
        st4_next.disc = sat_add(st3_reg.bb, -t);
    end

    ruci_sqrt u_sqrt (
        .aclk     (aclk),
        .en       (en),
        .radicand (st4_reg.disc),
        .root     (sq_root)
    );

    always_comb begin
        fx_t sq, v;
        sq = sq_ctx_reg[SQRT_STAGES].b;
        st5_next   = sq_ctx_reg[SQRT_STAGES];
        st5_next.s = sq_root;
        v          = sq[IW-1] ? sat_add(-sq, sq_root) : sat_add(-sq, -sq_root);
        st5_next.q = (v + fx_t'(v[IW-1])) >>> 1;
    end

    ruci_div u_div_qa (.aclk(aclk), .en(en), .num(st5_reg.q),   .den(st5_reg.a),  .quo(d_qa));
    ruci_div u_div_cq (.aclk(aclk), .en(en), .num(st5_reg.c),   .den(st5_reg.q),  .quo(d_cq));
    ruci_div u_div_t0 (.aclk(aclk), .en(en), .num(st5_reg.cn0), .den(st5_reg.dy), .quo(d_t0));
    ruci_div u_div_t1 (.aclk(aclk), .en(en), .num(st5_reg.cn1), .den(st5_reg.dy), .quo(d_t1));

    always_comb begin
        fx_t r1, r2;
        pipe_t cx;
        cx = dv_ctx_reg[DIV_STAGES];
        st6_next = cx;
        r1 = cx.b[IW-1] ? d_cq : d_qa;
        r2 = cx.b[IW-1] ? d_qa : d_cq;
        st6_next.tt = (r1 < eps) ? r2 : r1;
        st6_next.t0 = d_t0;
        st6_next.t1 = d_t1;
        st6_next.side_ok = (cx.disc > 0) && (cx.a != '0) && (cx.q != '0);
    end

    always_comb begin
        mp6_next[0] = mul_pp(st6_reg.tt, st6_reg.dy);
        mp6_next[1] = mul_pp(st6_reg.tt, st6_reg.dx);
        mp6_next[2] = mul_pp(st6_reg.tt, st6_reg.dz);
        mp6_next[3] = mul_pp(st6_reg.t0, st6_reg.dx);
        mp6_next[4] = mul_pp(st6_reg.t0, st6_reg.dz);
        mp6_next[5] = mul_pp(st6_reg.t1, st6_reg.dx);
        mp6_next[6] = mul_pp(st6_reg.t1, st6_reg.dz);
    end

    always_comb begin
        st7_next      = st6m_reg;
        st7_next.m_ty = mul_fin(mp6_reg[0]);
        st7_next.m_tx = mul_fin(mp6_reg[1]);
        st7_next.m_tz = mul_fin(mp6_reg[2]);
        st7_next.m_0x = mul_fin(mp6_reg[3]);
        st7_next.m_0z = mul_fin(mp6_reg[4]);
        st7_next.m_1x = mul_fin(mp6_reg[5]);
        st7_next.m_1z = mul_fin(mp6_reg[6]);
    end

    always_comb begin
        st8_next    = st7_reg;
        st8_next.y  = sat_add(st7_reg.oy, st7_reg.m_ty);
        st8_next.nx = sat_add(st7_reg.ox, st7_reg.m_tx);
        st8_next.nz = sat_add(st7_reg.oz, st7_reg.m_tz);
        st8_next.x0 = sat_add(st7_reg.ox, st7_reg.m_0x);
        st8_next.z0 = sat_add(st7_reg.oz, st7_reg.m_0z);
        st8_next.x1 = sat_add(st7_reg.ox, st7_reg.m_1x);
        st8_next.z1 = sat_add(st7_reg.oz, st7_reg.m_1z);
    end

    always_comb begin
        mp8_next[0] = mul_pp(st8_reg.x0, st8_reg.x0);
        mp8_next[1] = mul_pp(st8_reg.z0, st8_reg.z0);
        mp8_next[2] = mul_pp(st8_reg.x1, st8_reg.x1);
        mp8_next[3] = mul_pp(st8_reg.z1, st8_reg.z1);
    end

    always_comb begin
        st9_next     = st8m_reg;
        st9_next.sx0 = mul_fin(mp8_reg[0]);
        st9_next.sz0 = mul_fin(mp8_reg[1]);
        st9_next.sx1 = mul_fin(mp8_reg[2]);
        st9_next.sz1 = mul_fin(mp8_reg[3]);
    end

    always_comb begin
        fx_t best, nx, ny, nz;
        best     = st9_reg.best;
        nx       = '0;
        ny       = '0;
        nz       = '0;
        hit_next = 1'b0;
        if (st9_reg.side_ok && st9_reg.tt >= eps && st9_reg.tt <= best &&
            st9_reg.y < ONEV + eps && st9_reg.y > -ONEV - eps) begin
            best     = st9_reg.tt;
            nx       = st9_reg.nx;
            nz       = st9_reg.nz;
            hit_next = 1'b1;
        end
        if (st9_reg.dy != '0) begin
            if (st9_reg.t0 >= eps && st9_reg.t0 < best &&
                sat_add(st9_reg.sx0, st9_reg.sz0) <= ONEV + eps) begin
                best     = st9_reg.t0;
                nx       = '0;
                ny       = ONEV;
                nz       = '0;
                hit_next = 1'b1;
            end
            if (st9_reg.t1 >= eps && st9_reg.t1 < best &&
                sat_add(st9_reg.sx1, st9_reg.sz1) <= ONEV + eps) begin
                best     = st9_reg.t1;
                nx       = '0;
                ny       = -ONEV;
                nz       = '0;
                hit_next = 1'b1;
            end
        end
        m_tdata_next = OUT_W'({clamp_coord(nz), clamp_coord(ny), clamp_coord(nx),
                               best[DIST_WIDTH-1:0]});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st1_reg <= st1_next;
            st2_reg <= st2_next;
            st2m_reg <= st2_reg;
            for (int k = 0; k < 2; k++) mp2_reg[k] <= mp2_next[k];
            st3_reg <= st3_next;
            st4_reg <= st4_next;
            sq_ctx_reg[1] <= st4_reg;
            for (int k = 1; k < SQRT_STAGES; k++) sq_ctx_reg[k+1] <= sq_ctx_reg[k];
            st5_reg <= st5_next;
            dv_ctx_reg[1] <= st5_reg;
            for (int k = 1; k < DIV_STAGES; k++) dv_ctx_reg[k+1] <= dv_ctx_reg[k];
            st6_reg <= st6_next;
            st6m_reg <= st6_reg;
            for (int k = 0; k < 7; k++) mp6_reg[k] <= mp6_next[k];
            st7_reg <= st7_next;
            st8_reg <= st8_next;
            st8m_reg <= st8_reg;
            for (int k = 0; k < 4; k++) mp8_reg[k] <= mp8_next[k];
            st9_reg <= st9_next;
            m_tdata_reg <= m_tdata_next;
            hit_reg     <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v2m_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v6m_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v8m_reg <= 1'b0;
            v9_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int k = 1; k <= SQRT_STAGES; k++) sq_v_reg[k] <= 1'b0;
            for (int k = 1; k <= DIV_STAGES; k++) dv_v_reg[k] <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v2m_reg <= v2_reg;
            v3_reg <= v2m_reg;
            v4_reg <= v3_reg;
            sq_v_reg[1] <= v4_reg;
            for (int k = 1; k < SQRT_STAGES; k++) sq_v_reg[k+1] <= sq_v_reg[k];
            v5_reg <= sq_v_reg[SQRT_STAGES];
            dv_v_reg[1] <= v5_reg;
            for (int k = 1; k < DIV_STAGES; k++) dv_v_reg[k+1] <= dv_v_reg[k];
            v6_reg <= dv_v_reg[DIV_STAGES];
            v6m_reg <= v6_reg;
            v7_reg <= v6m_reg;
            v8_reg <= v7_reg;
            v8m_reg <= v8_reg;
            v9_reg <= v8m_reg;
            m_tvalid_reg <= v9_reg;
        end
    end

`ifndef ASSERT_OFF
    a_miss_zero_normal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[OUT_W-1:DIST_WIDTH] == '0)
        else $error("miss beat carries a nonzero normal");

    a_cap_normal_axis: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] && m_tdata[DIST_WIDTH+CW +: CW] != '0 |->
        m_tdata[DIST_WIDTH +: CW] == '0 && m_tdata[DIST_WIDTH+2*CW +: CW] == '0)
        else $error("cap hit with radial normal component");

    a_normal_y_codes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[DIST_WIDTH+CW +: CW] == '0 ||
        m_tdata[DIST_WIDTH+CW +: CW] == ONEV[CW-1:0] ||
        m_tdata[DIST_WIDTH+CW +: CW] == CW'(-ONEV))
        else $error("normal_y not 0 or +-1");

    a_eps_reset: assert property (@(posedge aclk)
        !aresetn |=> epsilon_reg == EPS_WIDTH'(1))
        else $error("epsilon not restored by reset");
`endif

endmodule
